// ===== hw/rtl/pnp_pkg.sv =====
// ----------------------------------------------------------------------------
// pnp_pkg
// Types, phase codes and character helpers shared by the pitch name parser.
// ----------------------------------------------------------------------------
package pnp_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned PcW     = 5;
  localparam int unsigned OctW    = 5;
  localparam int unsigned NoteW   = 7;
  localparam logic [OctW-1:0] OctSat = 5'd31;

  localparam logic [CharW-1:0] ChNul   = 8'h00;
  localparam logic [CharW-1:0] ChSharp = 8'h23;  // '#'
  localparam logic [CharW-1:0] ChMinus = 8'h2D;  // '-'
  localparam logic [CharW-1:0] ChZero  = 8'h30;  // '0'
  localparam logic [CharW-1:0] ChNine  = 8'h39;  // '9'
  localparam logic [CharW-1:0] ChUpS   = 8'h53;  // 'S'
  localparam logic [CharW-1:0] ChLowS  = 8'h73;  // 's'
  localparam logic [CharW-1:0] ChUpB   = 8'h42;  // 'B'
  localparam logic [CharW-1:0] ChLowB  = 8'h62;  // 'b'
  localparam logic [CharW-1:0] ChLowA  = 8'h61;  // 'a'
  localparam logic [CharW-1:0] ChLowZ  = 8'h7A;  // 'z'

  typedef enum logic [2:0] {
    PH_LETTER = 3'd0,
    PH_AFTER_LETTER = 3'd1,
    PH_AFTER_ACC = 3'd2,
    PH_AFTER_MINUS = 3'd3,
    PH_DIGITS = 3'd4,
    PH_DONE = 3'd5
  } pnp_phase_e;

  typedef struct packed {
    pnp_phase_e      phase;
    logic [PcW-1:0]  pitch_class;   // semitone plus one, 0..13
    logic            oct_neg;
    logic [OctW-1:0] oct_mag;       // saturates at OctSat
    logic            err;
  } pnp_state_t;

  typedef struct packed {
    logic [NoteW-1:0] key_num;
    logic             note_valid;
  } pnp_result_t;

  function automatic logic is_digit(input logic [CharW-1:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  // Semitone of a note letter plus one; zero when the character is no letter.
  function automatic logic [PcW-1:0] letter_pc(input logic [CharW-1:0] c);
    logic [CharW-1:0] u;
    logic [PcW-1:0]   r;
    u = ((c >= ChLowA) && (c <= ChLowZ)) ? (c & 8'hDF) : c;
    case (u)
      8'h43:   r = 5'd1;   // C
      8'h44:   r = 5'd3;   // D
      8'h45:   r = 5'd5;   // E
      8'h46:   r = 5'd6;   // F
      8'h47:   r = 5'd8;   // G
      8'h41:   r = 5'd10;  // A
      8'h42:   r = 5'd12;  // B
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // Shift one decimal digit into the octave magnitude, saturating.
  function automatic logic [OctW-1:0] add_digit(input logic [OctW-1:0] mag,
                                                input logic [CharW-1:0] c);
    logic [8:0] v;
    v = {4'd0, mag} * 9'd10 + {5'd0, c[3:0]};
    return (v > {4'd0, OctSat}) ? OctSat : v[OctW-1:0];
  endfunction

endpackage

// ===== hw/rtl/pitch_name_parser.sv =====
// ----------------------------------------------------------------------------
// pitch_name_parser
// Streaming parser of scientific pitch names, one character per transfer.
// ----------------------------------------------------------------------------
// Result path: a terminator waits in the input register, then its result is loaded into the output register.
// Throughput: one character per cycle; the input register only holds a
//   terminator while the output register is full and not taken.
// Reset: rst_ni clears the parse state to "expecting note letter" and
//   drops both pipeline valid bits.
module pitch_name_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [pnp_pkg::CharW-1:0]  char_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [pnp_pkg::NoteW-1:0]  key_num_o,
  output logic                       note_valid_o
);
  import pnp_pkg::*;

  // Input register.
  logic             in_vld_q;
  logic [CharW-1:0] char_q;

  // Output register.
  logic             out_vld_q, out_vld_d;
  pnp_result_t      res_q;

  logic        is_term;
  logic        advance;   // the held character is consumed this cycle
  logic        load_out;
  pnp_state_t  pstate;
  pnp_result_t res_calc;

  assign is_term = (char_q == ChNul);
  // Plain characters always advance; a terminator needs room in the output.
  assign advance  = in_vld_q && (!is_term || !out_vld_q || out_ready_i);
  assign load_out = advance && is_term;
  assign in_ready_o = !in_vld_q || advance;

  pnp_parse_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .char_i  (char_q),
    .state_o (pstate)
  );

  // Result comes from the state before the terminator resets it.
  pnp_note_calc u_calc (
    .state_i  (pstate),
    .result_o (res_calc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= char_byte_i;
    end
  end

  // Output valid: set on a new result, drop once transferred.
  always_comb begin
    out_vld_d = out_vld_q;
    if (load_out) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      res_q <= res_calc;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign key_num_o    = res_q.key_num;
  assign note_valid_o = res_q.note_valid;

endmodule

// ===== hw/rtl/pnp_parse_core.sv =====
// ----------------------------------------------------------------------------
// pnp_parse_core
// Parse state register and per-character next-state logic.
// ----------------------------------------------------------------------------
module pnp_parse_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [pnp_pkg::CharW-1:0] char_i,
  output pnp_pkg::pnp_state_t       state_o
);
  import pnp_pkg::*;

  pnp_state_t state_q, state_d;
  logic       dig;
  logic [PcW-1:0] lpc;

  assign dig = is_digit(char_i);
  assign lpc = letter_pc(char_i);

  always_comb begin
    state_d = state_q;
    if (step_i) begin
      if (char_i == ChNul) begin
        state_d.phase       = PH_LETTER;
        state_d.pitch_class = '0;
        state_d.oct_neg     = 1'b0;
        state_d.oct_mag     = '0;
        state_d.err         = 1'b0;
      end else if (!state_q.err) begin
        unique case (state_q.phase)
          PH_LETTER: begin
            if (lpc == '0) begin
              state_d.err = 1'b1;
            end else begin
              state_d.pitch_class = lpc;
              state_d.phase       = PH_AFTER_LETTER;
            end
          end
          PH_AFTER_LETTER: begin
            if (char_i == ChSharp || char_i == ChLowS || char_i == ChUpS) begin
              state_d.pitch_class = state_q.pitch_class + 5'd1;
              state_d.phase       = PH_AFTER_ACC;
            end else if (char_i == ChLowB || char_i == ChUpB) begin
              state_d.pitch_class = state_q.pitch_class - 5'd1;
              state_d.phase       = PH_AFTER_ACC;
            end else if (char_i == ChMinus) begin
              state_d.oct_neg = 1'b1;
              state_d.phase   = PH_AFTER_MINUS;
            end else if (dig) begin
              state_d.oct_mag = add_digit(state_q.oct_mag, char_i);
              state_d.phase   = PH_DIGITS;
            end else begin
              state_d.err = 1'b1;
            end
          end
          PH_AFTER_ACC: begin
            if (char_i == ChMinus) begin
              state_d.oct_neg = 1'b1;
              state_d.phase   = PH_AFTER_MINUS;
            end else if (dig) begin
              state_d.oct_mag = add_digit(state_q.oct_mag, char_i);
              state_d.phase   = PH_DIGITS;
            end else begin
              state_d.err = 1'b1;
            end
          end
          PH_AFTER_MINUS: begin
            if (dig) begin
              state_d.oct_mag = add_digit(state_q.oct_mag, char_i);
              state_d.phase   = PH_DIGITS;
            end else begin
              state_d.err = 1'b1;
            end
          end
          PH_DIGITS: begin
            if (dig) begin
              state_d.oct_mag = add_digit(state_q.oct_mag, char_i);
            end else begin
              state_d.phase = PH_DONE;
            end
          end
          default: begin
            // trailing characters: hold
          end
        endcase
      end
    end
  end

  always_comb begin
    state_o = state_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_LETTER, pitch_class: '0, oct_neg: 1'b0,
                   oct_mag: '0, err: 1'b0};
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/pnp_note_calc.sv =====
// ----------------------------------------------------------------------------
// pnp_note_calc
// Range check and MIDI note arithmetic on the current parse state.
// ----------------------------------------------------------------------------
module pnp_note_calc (
  input  pnp_pkg::pnp_state_t  state_i,
  output pnp_pkg::pnp_result_t result_o
);
  import pnp_pkg::*;

  logic       phase_ok;
  logic       oct_ok;
  logic [3:0] oct_p1;   // octave plus one, 0..10 when in range
  logic [7:0] note_p1;  // MIDI note plus one

  assign phase_ok = (state_i.phase == PH_DIGITS) || (state_i.phase == PH_DONE);
  assign oct_ok   = state_i.oct_neg ? (state_i.oct_mag <= 5'd1)
                                    : (state_i.oct_mag <= 5'd9);
  assign oct_p1   = state_i.oct_neg ? ((state_i.oct_mag == '0) ? 4'd1 : 4'd0)
                                    : (state_i.oct_mag[3:0] + 4'd1);
  assign note_p1  = {4'd0, oct_p1} * 8'd12 + {3'd0, state_i.pitch_class};

  always_comb begin
    result_o.note_valid = !state_i.err && phase_ok && oct_ok &&
                          (note_p1 != 8'd0) && (note_p1 <= 8'd128);
    result_o.key_num    = '0;
    if (result_o.note_valid) begin
      result_o.key_num = 7'(note_p1 - 8'd1);
    end
  end

endmodule

// ===== hw/rtl/pnp_checker.sv =====
// ----------------------------------------------------------------------------
// pnp_checker
// Port-level checks of the pitch name parser, bound to the top level.
// ----------------------------------------------------------------------------
module pnp_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic [pnp_pkg::CharW-1:0] char_byte_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [pnp_pkg::NoteW-1:0] key_num_o,
  input logic                      note_valid_o
);
  import pnp_pkg::*;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(key_num_o) &&
    $stable(note_valid_o))
    else $error("result changed while stalled");

  // Drop the note number on an invalid name.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !note_valid_o |-> key_num_o == '0)
    else $error("invalid result carries a note number");

  // A fresh result follows a terminator transfer.
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && char_byte_i == ChNul, 2))
    else $error("result without a terminator");

  // Backpressure on input only when the output is full and stalled.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output stall");

endmodule

bind pitch_name_parser pnp_checker u_pnp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .char_byte_i  (char_byte_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .key_num_o    (key_num_o),
  .note_valid_o (note_valid_o)
);

// ===== tb/sv/pitch_name_parser_tb.sv =====
// ----------------------------------------------------------------------------
// pitch_name_parser_tb
// Self-checking bench for the streaming pitch name parser. Note names go in
// one character per transfer. A cycle-free model of the parse state predicts
// the MIDI note and valid flag of each terminator, and the bench checks them
// in order against the output transfers. Both sides of the block idle and
// stall at random.
// ----------------------------------------------------------------------------
module pitch_name_parser_tb;
  import pnp_pkg::*;

  localparam int unsigned RandomChars   = 1700;
  localparam int unsigned QuietLimit    = 2000;  // cycles with no transfer at all
  localparam int unsigned PressureAfter = 40;    // results before the long hold-off
  localparam int unsigned PressureHold  = 400;
  localparam int unsigned DrainCycles   = 10;    // idle wait before judging

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [CharW-1:0] char_byte_i = ChNul;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [NoteW-1:0] key_num_o;
  logic             note_valid_o;

  pitch_name_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_byte_i (char_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .key_num_o   (key_num_o),
    .note_valid_o(note_valid_o)
  );

  always #1 clk_i = ~clk_i;

  // Characters waiting to be sent, and the notes the parser owes us.
  logic [CharW-1:0] char_q[$];
  pnp_result_t      note_expect_q[$];

  // Predicted parse state, updated on every accepted character.
  pnp_phase_e       ph = PH_LETTER;
  logic [PcW-1:0]   pc_plus1 = '0;
  logic             oct_neg = 1'b0;
  logic [OctW-1:0]  oct_mag = '0;
  logic             bad = 1'b0;

  int unsigned chars_in = 0;
  int unsigned notes_ok = 0;
  int unsigned notes_rejected = 0;
  int unsigned results_seen = 0;
  int unsigned fail_cnt = 0;
  int unsigned quiet = 0;
  bit          pressure_done = 1'b0;
  pnp_result_t want_note;

  // Semitone of a note letter plus one, either case; zero for anything else.
  function automatic logic [PcW-1:0] letter_offset(input logic [CharW-1:0] c);
    logic [CharW-1:0] u;
    u = (c >= ChLowA && c <= ChLowZ) ? c - 8'd32 : c;
    case (u)
      8'h43:   return 5'd1;   // C
      8'h44:   return 5'd3;   // D
      8'h45:   return 5'd5;   // E
      8'h46:   return 5'd6;   // F
      8'h47:   return 5'd8;   // G
      8'h41:   return 5'd10;  // A
      8'h42:   return 5'd12;  // B
      default: return 5'd0;
    endcase
  endfunction

  // Advance the predicted parse state by one character; a terminator closes
  // the name, queues the note it stands for and clears the state.
  task automatic parse_char(input logic [CharW-1:0] c);
    logic             dig;
    logic [PcW-1:0]   lpc;
    int               v;
    int               oct;
    int               note;
    pnp_result_t      res;
    dig = (c >= ChZero) && (c <= ChNine);
    if (c == ChNul) begin
      res = '0;
      if (!bad && (ph == PH_DIGITS || ph == PH_DONE) && oct_mag != OctSat) begin
        oct  = oct_neg ? -int'(oct_mag) : int'(oct_mag);
        note = (oct + 1) * 12 + int'(pc_plus1) - 1;
        if (oct >= -1 && oct <= 9 && note >= 0 && note <= 127) begin
          res.key_num    = note[NoteW-1:0];
          res.note_valid = 1'b1;
        end
      end
      note_expect_q.push_back(res);
      ph       = PH_LETTER;
      pc_plus1 = '0;
      oct_neg  = 1'b0;
      oct_mag  = '0;
      bad      = 1'b0;
    end else if (!bad) begin
      case (ph)
        PH_LETTER: begin
          lpc = letter_offset(c);
          if (lpc == '0) begin
            bad = 1'b1;
          end else begin
            pc_plus1 = lpc;
            ph       = PH_AFTER_LETTER;
          end
        end
        PH_AFTER_LETTER, PH_AFTER_ACC: begin
          // The accidental is only allowed right after the letter.
          if (ph == PH_AFTER_LETTER && (c == ChSharp || c == ChLowS || c == ChUpS)) begin
            pc_plus1 = pc_plus1 + 5'd1;
            ph       = PH_AFTER_ACC;
          end else if (ph == PH_AFTER_LETTER && (c == ChLowB || c == ChUpB)) begin
            pc_plus1 = pc_plus1 - 5'd1;
            ph       = PH_AFTER_ACC;
          end else if (c == ChMinus) begin
            oct_neg = 1'b1;
            ph      = PH_AFTER_MINUS;
          end else if (dig) begin
            v       = int'(oct_mag) * 10 + int'(c - ChZero);
            oct_mag = (v > int'(OctSat)) ? OctSat : OctW'(v);
            ph      = PH_DIGITS;
          end else begin
            bad = 1'b1;
          end
        end
        PH_AFTER_MINUS: begin
          if (dig) begin
            v       = int'(oct_mag) * 10 + int'(c - ChZero);
            oct_mag = (v > int'(OctSat)) ? OctSat : OctW'(v);
            ph      = PH_DIGITS;
          end else begin
            bad = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (dig) begin
            v       = int'(oct_mag) * 10 + int'(c - ChZero);
            oct_mag = (v > int'(OctSat)) ? OctSat : OctW'(v);
          end else begin
            ph = PH_DONE;
          end
        end
        default: ;  // trailing characters are ignored up to the terminator
      endcase
    end
  endtask

  // Gap length: mostly short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(25, 80);
  endfunction

  task automatic add_name(input string s);
    for (int i = 0; i < s.len(); i++) char_q.push_back(s[i]);
    char_q.push_back(ChNul);
  endtask

  // One random name: mostly well-formed with random letter case, accidental,
  // sign, digit count and trailing junk; some with one character corrupted,
  // some pure noise.
  task automatic add_random_name();
    logic [CharW-1:0] nm[$];
    string            letters;
    int               kind;
    int               n;
    int               k;
    letters = "CDEFGAB";
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      n = $urandom_range(0, 4);
      repeat (n) nm.push_back(8'($urandom_range(1, 255)));
    end else begin
      nm.push_back(letters[$urandom_range(0, 6)] | ($urandom_range(0, 1) ? 8'h20 : 8'h00));
      case ($urandom_range(0, 6))
        1:       nm.push_back(ChSharp);
        2:       nm.push_back(ChLowS);
        3:       nm.push_back(ChUpS);
        4:       nm.push_back(ChLowB);
        5:       nm.push_back(ChUpB);
        default: ;
      endcase
      if ($urandom_range(0, 3) == 0) nm.push_back(ChMinus);
      n = ($urandom_range(0, 19) == 0) ? 3 : (($urandom_range(0, 4) == 0) ? 2 : 1);
      repeat (n) nm.push_back(ChZero + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) nm.push_back(8'($urandom_range(1, 255)));
      end
      if (kind == 1) begin
        k = $urandom_range(0, nm.size() - 1);
        nm[k] = 8'($urandom_range(1, 255));
      end
    end
    foreach (nm[i]) char_q.push_back(nm[i]);
    char_q.push_back(ChNul);
  endtask

  // Fill the character queue before the first edge after reset.
  initial begin
    // Lowest note, highest note, one semitone past each end.
    add_name("C-1");
    add_name("G9");
    add_name("G#9");
    add_name("Cb-1");
    // Lower case, 's' sharp, leading zero, junk after the digits.
    add_name("as04x");
    // Empty name, bad letter, flat then minus with no digits, minus zero.
    add_name("");
    add_name("H");
    add_name("BB-");
    add_name("d-0");
    // Octave that saturates the accumulator.
    add_name("FS99");
    while (char_q.size() < RandomChars + 40) add_random_name();
  end

  // Sender: offer the next character as soon as the previous one transferred,
  // with random gaps except during calm stretches.
  int unsigned tx_gap = 0;
  int unsigned tx_calm_left = 0;
  bit          tx_calm = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      char_byte_i <= ChNul;
      tx_gap      <= 0;
    end else begin
      if (tx_calm_left == 0) begin
        tx_calm      <= ~tx_calm;
        tx_calm_left <= $urandom_range(40, 400);
      end else begin
        tx_calm_left <= tx_calm_left - 1;
      end
      // Hold the current character until it transfers.
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap != 0) begin
          in_valid_i <= 1'b0;
          tx_gap     <= tx_gap - 1;
        end else if (char_q.size() != 0) begin
          in_valid_i  <= 1'b1;
          char_byte_i <= char_q.pop_front();
          if (!tx_calm && $urandom_range(0, 99) < 30) tx_gap <= pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, calm stretches, and one long hold-off that
  // fills the output register and backs up the input.
  int unsigned rx_hold = 0;
  int unsigned rx_calm_left = 0;
  bit          rx_calm = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_hold     <= 0;
    end else begin
      if (rx_calm_left == 0) begin
        rx_calm      <= ~rx_calm;
        rx_calm_left <= $urandom_range(40, 400);
      end else begin
        rx_calm_left <= rx_calm_left - 1;
      end
      if (!pressure_done && results_seen >= PressureAfter) begin
        pressure_done <= 1'b1;
        rx_hold       <= PressureHold;
        out_ready_i   <= 1'b0;
      end else if (rx_hold != 0) begin
        rx_hold     <= rx_hold - 1;
        out_ready_i <= 1'b0;
      end else if (rx_calm || $urandom_range(0, 99) < 75) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        rx_hold     <= pick_gap();
      end
    end
  end

  // Monitor: predict on each character transfer, check each note transfer
  // against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        parse_char(char_byte_i);
        chars_in++;
      end
      if (out_valid_o && out_ready_i) begin
        results_seen <= results_seen + 1;
        if (note_valid_o) notes_ok++;
        else notes_rejected++;
        if (note_expect_q.size() == 0) begin
          $display("%0t: note transfer with none pending: note=%0d valid=%0b",
                   $time, key_num_o, note_valid_o);
          fail_cnt++;
        end else begin
          want_note = note_expect_q.pop_front();
          if (want_note.key_num !== key_num_o) begin
            $display("%0t: key_num expected %0d actual %0d",
                     $time, want_note.key_num, key_num_o);
            fail_cnt++;
          end
          if (want_note.note_valid !== note_valid_o) begin
            $display("%0t: note_valid expected %0b actual %0b",
                     $time, want_note.note_valid, note_valid_o);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: drop the run when neither side transfers for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet <= 0;
      end else if (quiet >= QuietLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet);
        $display("pitch_name_parser verification failed");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // Reset, then wait for every character and every note before judging.
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (char_q.size() != 0 || in_valid_i || note_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (note_expect_q.size() != 0) begin
      $display("%0t: %0d notes never arrived", $time, note_expect_q.size());
      fail_cnt++;
    end
    $display("Parsed %0d characters into %0d names: %0d valid notes, %0d rejected.",
             chars_in, notes_ok + notes_rejected, notes_ok, notes_rejected);
    $display("Long output hold-off %0s; %0d mismatches.",
             pressure_done ? "exercised" : "not reached", fail_cnt);
    if (fail_cnt == 0) begin
      $display("pitch_name_parser verification clean");
    end else begin
      $display("pitch_name_parser verification failed");
    end
    $finish;
  end

endmodule
